[hdl/iss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

    // Request codes.
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 9;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_RDWAIT = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[hdl/iss_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module iss_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/indexed_sequence_store.sv]
// Ordered store of up to CAPACITY signed 32-bit values held in one synchronous
// RAM (one read port, one write port, registered read). A request is taken
// only while the block is idle, and its single result is parked in an output
// register, so the next request can enter while that result still waits to
// be taken. An append passes from S_EXEC to S_DONE, a read waits in S_RDWAIT
// between them, and a remove passes through S_SHIFT: closing the gap moves
// every later element one place forward, one element per cycle through the
// RAM's read and write ports. Out-of-range requests and a full append go from
// S_EXEC straight to S_DONE. The RAM needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store
    import iss_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire logic [1:0]               req_type,
    input  wire logic signed [DATA_W-1:0] data_value,
    input  wire logic [POS_W-1:0]         position,
    output logic                          rsp_valid,
    input  wire logic                     rsp_stall,
    output logic signed [DATA_W-1:0]      read_value,
    output logic [1:0]                    status,
    output logic [COUNT_W-1:0]            element_count
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int XW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [1:0]          kind_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [DATA_W-1:0]   res_value_reg, res_value_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0]   rsp_value_reg;
    logic [1:0]          rsp_status_reg;
    logic [COUNT_W-1:0]  rsp_count_reg;

    logic                ram_re, ram_we;
    logic [AW-1:0]       ram_raddr, ram_waddr;
    logic [DATA_W-1:0]   ram_rdata, ram_wdata;

    logic                req_xfer, rsp_load, in_range, rd_issue;
    logic [CW-1:0]       pos_ext, cnt_ext;
    logic [XW-1:0]       cnt_wide;

    iss_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (AW),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    assign pos_ext  = CW'(pos_reg);
    assign cnt_ext  = CW'(count_reg);
    assign in_range = pos_ext < cnt_ext;
    assign rd_issue = rd_ptr_reg < count_reg;
    assign cnt_wide = XW'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        wr_pend_next    = wr_pend_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        ram_re          = 1'b0;
        ram_raddr       = rd_ptr_reg[AW-1:0];
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg[AW-1:0];
        ram_wdata       = ram_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_value_next  = '0;
                res_status_next = ST_OK;
                state_next      = S_DONE;
                case (kind_reg)
                    REQ_APPEND:
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            ram_wdata  = value_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    REQ_READ:
                    begin
                        if (!in_range)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = pos_ext[AW-1:0];
                            state_next = S_RDWAIT;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!in_range)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else
                        begin
                            wr_ptr_next  = pos_ext[CNT_W-1:0];
                            rd_ptr_next  = pos_ext[CNT_W-1:0] + 1'b1;
                            wr_pend_next = 1'b0;
                            state_next   = S_SHIFT;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_RDWAIT:
            begin
                res_value_next = ram_rdata;
                state_next     = S_DONE;
            end
            S_SHIFT:
            begin
                // Reads run one entry ahead of writes, so the element read in
                // the previous cycle lands one place lower in this cycle.
                if (rd_issue)
                begin
                    ram_re      = 1'b1;
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                wr_pend_next = rd_issue;
                if (wr_pend_reg)
                begin
                    ram_we      = 1'b1;
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                if (!rd_issue)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            kind_reg  <= req_type;
            value_reg <= $unsigned(data_value);
            pos_reg   <= position;
        end
        rd_ptr_reg     <= rd_ptr_next;
        wr_ptr_reg     <= wr_ptr_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (rsp_load)
        begin
            rsp_value_reg  <= res_value_reg;
            rsp_status_reg <= res_status_reg;
            rsp_count_reg  <= cnt_wide[COUNT_W-1:0];
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign read_value    = $signed(rsp_value_reg);
    assign status        = rsp_status_reg;
    assign element_count = rsp_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count exceeds capacity");

    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) && wr_pend_reg |-> wr_ptr_reg < rd_ptr_reg)
        else $error("gap-closing write overtook its read");

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re && ram_we |-> ram_raddr != ram_waddr)
        else $error("RAM read and write at the same entry");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) && !rd_issue |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not drop the count by one");

endmodule

`default_nettype wire
